### sv/prm_pkg.sv
// Shared types, widths and the power-up polygon for the polygon region membership test.
// No dependencies; compiled first.
`default_nettype none

package prm_pkg;

	localparam int MAX_VERTICES    = 32;
	localparam int VIDX_W          = $clog2(MAX_VERTICES);
	localparam int CNT_W           = 6;
	localparam int LAT_W           = 16;
	localparam int LON_W           = 17;
	localparam int ANGLE_FRAC_BITS = 8;
	localparam int DEFAULT_N       = 12;
	localparam int PROD_W          = LAT_W + LON_W + 2;
	localparam int DIV_CNT_W       = $clog2(PROD_W + 1);

	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(12);

	localparam int DEF_LAT_DEG [DEFAULT_N] = '{-30, -26, -20, -17, -10, 1, 2, -3, -8, -12, -19, -30};
	localparam int DEF_LON_DEG [DEFAULT_N] = '{45, 41, 31, 9, -11, -34, -46, -62, -79, -85, -89, -87};

	typedef struct packed {
		logic signed [LAT_W-1:0] lat;
		logic signed [LON_W-1:0] lon;
	} vertex_t;

	// Power-up table contents: default polygon in fixed point, zeros beyond it.
	function automatic vertex_t default_vertex(input logic [VIDX_W-1:0] idx);
		vertex_t v;
		v.lat = '0;
		v.lon = '0;
		for (int k = 0; k < DEFAULT_N; k++) begin
			if (int'(idx) == k) begin
				v.lat = LAT_W'(DEF_LAT_DEG[k] * (1 << ANGLE_FRAC_BITS));
				v.lon = LON_W'(DEF_LON_DEG[k] * (1 << ANGLE_FRAC_BITS));
			end
		end
		return v;
	endfunction

endpackage

`default_nettype wire

### sv/prm_if.sv
// Request, response and configuration channels of the polygon region membership test.
// Depends on prm_pkg for field widths.
`default_nettype none

interface prm_req_if import prm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    mode;
	logic [VIDX_W-1:0]       vertex_index;
	logic signed [LAT_W-1:0] lat_value;
	logic signed [LON_W-1:0] lon_value;

	modport source (output valid, output mode, output vertex_index, output lat_value,
		output lon_value, input ready);
	modport sink (input valid, input mode, input vertex_index, input lat_value,
		input lon_value, output ready);
endinterface

interface prm_rsp_if import prm_pkg::*; ();
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, output inside_res, input ready);
	modport sink (input valid, input inside_res, output ready);
endinterface

interface prm_cfg_if import prm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] vertex_count;

	modport source (output valid, output vertex_count, input ready);
	modport sink (input valid, input vertex_count, output ready);
endinterface

`default_nettype wire

### sv/polygon_region_membership_test.sv
// Top level of the polygon region membership test: vertex memory, query sequencer,
// bounding box and bit-serial crossing divider. Depends on prm_pkg and prm_if.
`default_nettype none

// A vertex write request (mode 1) gives no response. A query request (mode 0) gives one
// response; it first rebuilds the bounding box when the table or vertex_count changed
// since the last query, then scans the vertices east and west, and runs the divider for
// each edge crossing that needs a division (at most two per query); vertex_count is
// capped at 32. The vertex memory has a single read port, and the divider produces one
// quotient bit per cycle. New requests are taken while the previous response still
// waits in the output register.
module polygon_region_membership_test import prm_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	prm_req_if.sink   req,
	prm_rsp_if.source rsp,
	prm_cfg_if.sink   cfg
);

	typedef enum logic [11:0] {
		ST_IDLE    = 12'b0000_0000_0001,
		ST_BOX_RD  = 12'b0000_0000_0010,
		ST_BOX_AC  = 12'b0000_0000_0100,
		ST_BOX_CHK = 12'b0000_0000_1000,
		ST_SCAN_RD = 12'b0000_0001_0000,
		ST_SCAN_AC = 12'b0000_0010_0000,
		ST_EDGE    = 12'b0000_0100_0000,
		ST_MUL     = 12'b0000_1000_0000,
		ST_DIV_LD  = 12'b0001_0000_0000,
		ST_DIV     = 12'b0010_0000_0000,
		ST_CMP     = 12'b0100_0000_0000,
		ST_DONE    = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	// control state
	logic                  stale_q;
	logic [MAX_VERTICES-1:0] vtx_vld_q;
	logic [CNT_W-1:0]      vcount_q;
	logic [CNT_W-1:0]      box_idx_q;
	logic [CNT_W-1:0]      scan_idx_q;
	logic                  east_q;
	logic                  first_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic                  rsp_valid_q;

	// payload
	vertex_t               vtx_mem [MAX_VERTICES];
	vertex_t               rd_data_s1;
	logic                  rd_vld_s1;
	logic [VIDX_W-1:0]     rd_addr_s1;
	logic signed [LAT_W-1:0] q_lat_q;
	logic signed [LON_W-1:0] q_lon_q;
	vertex_t               cur_q, prev_q;
	logic signed [LAT_W-1:0] box_lat_lo_q, box_lat_hi_q;
	logic signed [LON_W-1:0] box_lon_lo_q, box_lon_hi_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0]     num_q;
	logic [LAT_W:0]        den_q;
	logic [LAT_W+1:0]      rem_q;
	logic                  neg_q;
	logic                  done_res_q;
	logic                  rsp_res_q;

	// combinational
	logic                  req_acc, wr_acc, q_acc, cfg_acc;
	logic [CNT_W-1:0]      used_n;
	logic                  rd_en;
	logic [VIDX_W-1:0]     rd_addr;
	vertex_t               cur_vtx;
	logic                  scan_go;
	logic                  side_i, side_p;
	logic                  box_out;
	logic signed [LAT_W:0] dlat;
	logic signed [LON_W:0] dlon;
	logic signed [LAT_W:0] dy;
	logic [LAT_W+1:0]      rem_sh;
	logic                  rem_ge;
	logic signed [PROD_W:0]   quo_s;
	logic signed [PROD_W+1:0] cross_lon;
	logic                  cross_rej;
	logic                  go_done;
	logic                  fin_res;
	logic                  rsp_load;

	assign req_acc = req.valid && req.ready;
	assign wr_acc  = req_acc && req.mode;
	assign q_acc   = req_acc && !req.mode;
	assign cfg_acc = cfg.valid && cfg.ready;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.inside_res = rsp_res_q;

	assign used_n = (vcount_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_q;

	assign rd_en = ((state_q == ST_BOX_RD) && (box_idx_q < used_n)) ||
		((state_q == ST_SCAN_RD) && (scan_idx_q < used_n));
	assign rd_addr = (state_q == ST_BOX_RD) ? box_idx_q[VIDX_W-1:0] : scan_idx_q[VIDX_W-1:0];

	// never-written entries read as the power-up polygon
	assign cur_vtx = rd_vld_s1 ? rd_data_s1 : default_vertex(rd_addr_s1);

	assign scan_go = east_q ? (cur_vtx.lat < q_lat_q) : (cur_vtx.lat > q_lat_q);
	assign side_i  = east_q ? (cur_q.lon < q_lon_q) : (cur_q.lon > q_lon_q);
	assign side_p  = east_q ? (prev_q.lon < q_lon_q) : (prev_q.lon > q_lon_q);

	assign box_out = (q_lon_q < box_lon_lo_q) || (q_lon_q > box_lon_hi_q) ||
		(q_lat_q < box_lat_lo_q) || (q_lat_q > box_lat_hi_q);

	assign dlat = (LAT_W+1)'(cur_q.lat) - (LAT_W+1)'(prev_q.lat);
	assign dlon = (LON_W+1)'(cur_q.lon) - (LON_W+1)'(prev_q.lon);
	assign dy   = (LAT_W+1)'(q_lat_q) - (LAT_W+1)'(cur_q.lat);

	assign rem_sh = {rem_q[LAT_W:0], num_q[PROD_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, den_q});

	assign quo_s     = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
	assign cross_lon = (PROD_W+2)'(cur_q.lon) + (PROD_W+2)'(quo_s);
	assign cross_rej = east_q ? (cross_lon < (PROD_W+2)'(q_lon_q)) :
		(cross_lon > (PROD_W+2)'(q_lon_q));

	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// next state and the answer carried into the done state
	always_comb begin
		state_d = state_q;
		go_done = 1'b0;
		fin_res = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_acc) begin
					if (used_n == '0) begin
						state_d = ST_DONE;
						go_done = 1'b1;
					end else if (stale_q) begin
						state_d = ST_BOX_RD;
					end else begin
						state_d = ST_BOX_CHK;
					end
				end
			end
			ST_BOX_RD: begin
				state_d = (box_idx_q < used_n) ? ST_BOX_AC : ST_BOX_CHK;
			end
			ST_BOX_AC: begin
				state_d = ST_BOX_RD;
			end
			ST_BOX_CHK: begin
				if (box_out) begin
					state_d = ST_DONE;
					go_done = 1'b1;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				if (scan_idx_q < used_n) begin
					state_d = ST_SCAN_AC;
				end else begin
					state_d = ST_DONE;
					go_done = 1'b1;
				end
			end
			ST_SCAN_AC: begin
				state_d = scan_go ? ST_SCAN_RD : ST_EDGE;
			end
			ST_EDGE: begin
				if (side_i && side_p) begin
					state_d = ST_DONE;
					go_done = 1'b1;
				end else if (side_i || side_p) begin
					state_d = (dlat == '0) ? ST_CMP : ST_MUL;
				end else if (east_q) begin
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_DONE;
					go_done = 1'b1;
					fin_res = 1'b1;
				end
			end
			ST_MUL: begin
				state_d = ST_DIV_LD;
			end
			ST_DIV_LD: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(1)) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (cross_rej) begin
					state_d = ST_DONE;
					go_done = 1'b1;
				end else if (east_q) begin
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_DONE;
					go_done = 1'b1;
					fin_res = 1'b1;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stale_q     <= 1'b1;
			vtx_vld_q   <= '0;
			vcount_q    <= COUNT_RESET;
			box_idx_q   <= '0;
			scan_idx_q  <= '0;
			east_q      <= 1'b1;
			first_q     <= 1'b1;
			div_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_acc) begin
				vcount_q <= cfg.vertex_count;
			end
			if (wr_acc) begin
				vtx_vld_q[req.vertex_index] <= 1'b1;
			end
			if (cfg_acc || wr_acc) begin
				stale_q <= 1'b1;
			end else if ((state_q == ST_BOX_RD) && (box_idx_q >= used_n)) begin
				stale_q <= 1'b0;
			end

			if (q_acc) begin
				box_idx_q <= '0;
			end else if (state_q == ST_BOX_AC) begin
				box_idx_q <= box_idx_q + 1'b1;
			end

			if (state_q == ST_BOX_CHK) begin
				scan_idx_q <= '0;
				east_q     <= 1'b1;
				first_q    <= 1'b1;
			end else if ((state_q == ST_SCAN_AC) && scan_go) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				first_q    <= 1'b0;
			end else if (((state_q == ST_EDGE) && !side_i && !side_p && east_q) ||
				((state_q == ST_CMP) && !cross_rej && east_q)) begin
				// step past a vertex that sits exactly on the latitude, then go west
				east_q <= 1'b0;
				if (cur_q.lat == q_lat_q) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end

			if (state_q == ST_DIV_LD) begin
				div_cnt_q <= DIV_CNT_W'(PROD_W);
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// vertex memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_acc) begin
			vtx_mem[req.vertex_index] <= '{lat: req.lat_value, lon: req.lon_value};
		end
		if (rd_en) begin
			rd_data_s1 <= vtx_mem[rd_addr];
			rd_vld_s1  <= vtx_vld_q[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (q_acc) begin
			q_lat_q <= req.lat_value;
			q_lon_q <= req.lon_value;
		end

		if (state_q == ST_BOX_AC) begin
			if (box_idx_q == '0) begin
				box_lat_lo_q <= cur_vtx.lat;
				box_lat_hi_q <= cur_vtx.lat;
				box_lon_lo_q <= cur_vtx.lon;
				box_lon_hi_q <= cur_vtx.lon;
			end else begin
				if (cur_vtx.lat < box_lat_lo_q) box_lat_lo_q <= cur_vtx.lat;
				if (cur_vtx.lat > box_lat_hi_q) box_lat_hi_q <= cur_vtx.lat;
				if (cur_vtx.lon < box_lon_lo_q) box_lon_lo_q <= cur_vtx.lon;
				if (cur_vtx.lon > box_lon_hi_q) box_lon_hi_q <= cur_vtx.lon;
			end
		end

		if (state_q == ST_SCAN_AC) begin
			if (scan_go || first_q) begin
				prev_q <= cur_vtx;
			end
			cur_q <= cur_vtx;
		end else if (((state_q == ST_EDGE) && !side_i && !side_p && east_q) ||
			((state_q == ST_CMP) && !cross_rej && east_q)) begin
			if (cur_q.lat == q_lat_q) begin
				prev_q <= cur_q;
			end
		end

		if ((state_q == ST_EDGE) && (dlat == '0)) begin
			// flat edge: crossing is the vertex longitude itself
			num_q <= '0;
			neg_q <= 1'b0;
		end else if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(dy * dlon);
		end else if (state_q == ST_DIV_LD) begin
			num_q <= prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
			den_q <= dlat[LAT_W] ? (LAT_W+1)'(-dlat) : (LAT_W+1)'(dlat);
			neg_q <= prod_q[PROD_W-1] ^ dlat[LAT_W];
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
			num_q <= {num_q[PROD_W-2:0], rem_ge};
		end

		if (go_done) begin
			done_res_q <= fin_res;
		end
		if (rsp_load) begin
			rsp_res_q <= done_res_q;
		end
	end

	// a vertex write marks its entry as written
	a_wr_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_acc |=> vtx_vld_q[$past(req.vertex_index)])
		else $error("written vertex entry not marked valid");

	// the divider never runs against a zero denominator
	a_div_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (den_q != '0))
		else $error("crossing division with zero latitude span");

	// a scan read lands only on vertices in use
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_AC) |-> (scan_idx_q < used_n))
		else $error("scan read beyond vertices in use");

	// a finished box rebuild leaves the box current
	a_box_clears_stale: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_BOX_RD) && (box_idx_q >= used_n) && !cfg_acc) |=> !stale_q)
		else $error("box still stale after rebuild");

	// a response is loaded only from the done state
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("response raised outside done state");

endmodule

`default_nettype wire
